// ===== design/pitr_pkg.sv =====
// ----------------------------------------------------------------------------
// pitr_pkg: shared types and constants for the triangle-mesh ray parity block
// Holds function codes, default sizes, the field and crossing-count widths and the hit type.
// ----------------------------------------------------------------------------
package pitr_pkg;

    localparam int MAX_TRIANGLES_DEF = 1024;
    localparam int COORD_BITS_DEF    = 20;
    localparam int FIELD_BITS        = 20;
    localparam int CROSS_BITS        = 11;

    typedef enum logic [1:0] {
        FUNC_CLEAR = 2'd0,
        FUNC_ADD   = 2'd1,
        FUNC_QUERY = 2'd2,
        FUNC_NONE  = 2'd3
    } t_func;

    typedef struct packed {
        logic                  hit;
    } t_hit;

endpackage

// ===== design/pitr_if.sv =====
// ----------------------------------------------------------------------------
// pitr_in_if / pitr_out_if: valid-ready channels of the ray parity block
// Input carries the function code and nine coordinates; output the result.
// ----------------------------------------------------------------------------
interface pitr_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic signed [pitr_pkg::FIELD_BITS-1:0] vert_a_x, vert_a_y, vert_a_z;
    logic signed [pitr_pkg::FIELD_BITS-1:0] vert_b_x, vert_b_y, vert_b_z;
    logic signed [pitr_pkg::FIELD_BITS-1:0] vert_c_x, vert_c_y, vert_c_z;
    modport source (output valid, func, vert_a_x, vert_a_y, vert_a_z, vert_b_x,
                    vert_b_y, vert_b_z, vert_c_x, vert_c_y, vert_c_z, input ready);
    modport sink   (input valid, func, vert_a_x, vert_a_y, vert_a_z, vert_b_x,
                    vert_b_y, vert_b_z, vert_c_x, vert_c_y, vert_c_z, output ready);
endinterface

interface pitr_out_if;
    logic        valid;
    logic        ready;
    logic        inside_res;
    logic [pitr_pkg::CROSS_BITS-1:0] crossings;
    logic        status;
    modport source (output valid, inside_res, crossings, status, input ready);
    modport sink   (input valid, inside_res, crossings, status, output ready);
endinterface

// ===== design/point_in_trimesh_ray_parity_top.sv =====
// ----------------------------------------------------------------------------
// point_in_trimesh_ray_parity_top: point in closed triangle surface by parity
// Stores triangles, keeps their bounding box and counts +z ray crossings.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake    | payload
//  ---------+-----+--------------+------------------------------------------
//  s_in     | in  | valid/ready  | func, vert_{a,b,c}_{x,y,z}
//  m_out    | out | valid/ready  | inside_res, crossings, status
//
//  Clear, add, unused codes and queries outside the box present their
//  result one cycle after acceptance.
//  A query in the box walks all stored triangles, one per cycle, through
//  the single read port of the triangle memory into the pipelined
//  intersection unit, then drains the unit before presenting the result.
//  Input ready is low from acceptance until the result item is taken.
//  Reset clears the count and box; the triangle memory needs no clearing.
// ----------------------------------------------------------------------------
module point_in_trimesh_ray_parity_top #(
    parameter int MAX_TRIANGLES = pitr_pkg::MAX_TRIANGLES_DEF,
    parameter int COORD_BITS    = pitr_pkg::COORD_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    pitr_in_if.sink    s_in,
    pitr_out_if.source m_out
);
    localparam int CB = COORD_BITS;
    localparam int AW = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
    localparam int NW = $clog2(MAX_TRIANGLES + 1);
    localparam int VW = 3 * CB;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_WALK = 4'b0010,
        ST_LAST = 4'b0100,
        ST_OUT  = 4'b1000
    } t_state;

    t_state r_state;
    logic [NW-1:0] r_count, r_rd, r_hits;
    logic          r_empty;
    logic signed [CB-1:0] r_min [3];
    logic signed [CB-1:0] r_max [3];
    logic signed [CB-1:0] r_p   [3];
    logic          r_inside, r_status;
    logic [pitr_pkg::CROSS_BITS-1:0] r_cross;
    logic          r_rvalid;

    logic [VW-1:0] mem_a [MAX_TRIANGLES];
    logic [VW-1:0] mem_b [MAX_TRIANGLES];
    logic [VW-1:0] mem_c [MAX_TRIANGLES];
    logic [VW-1:0] r_ra, r_rb, r_rc;

    // take coordinates as their low COORD_BITS bits
    logic signed [CB-1:0] v [9];
    assign v[0] = CB'($unsigned(s_in.vert_a_x));
    assign v[1] = CB'($unsigned(s_in.vert_a_y));
    assign v[2] = CB'($unsigned(s_in.vert_a_z));
    assign v[3] = CB'($unsigned(s_in.vert_b_x));
    assign v[4] = CB'($unsigned(s_in.vert_b_y));
    assign v[5] = CB'($unsigned(s_in.vert_b_z));
    assign v[6] = CB'($unsigned(s_in.vert_c_x));
    assign v[7] = CB'($unsigned(s_in.vert_c_y));
    assign v[8] = CB'($unsigned(s_in.vert_c_z));

    logic acc;
    assign acc        = s_in.valid && s_in.ready;
    assign s_in.ready = (r_state == ST_IDLE);

    logic full, in_box, do_add;
    assign full = (r_count >= NW'(MAX_TRIANGLES));
    always_comb begin
        in_box = !r_empty;
        for (int i = 0; i < 3; i++)
            if (v[i] < r_min[i] || v[i] > r_max[i]) in_box = 1'b0;
    end
    assign do_add = acc && (s_in.func == pitr_pkg::FUNC_ADD) && !full;

    // store triangle and register the read at the walk address
    always_ff @(posedge i_clk) begin
        if (do_add) begin
            mem_a[r_count[AW-1:0]] <= {v[2], v[1], v[0]};
            mem_b[r_count[AW-1:0]] <= {v[5], v[4], v[3]};
            mem_c[r_count[AW-1:0]] <= {v[8], v[7], v[6]};
        end
        r_ra <= mem_a[r_rd[AW-1:0]];
        r_rb <= mem_b[r_rd[AW-1:0]];
        r_rc <= mem_c[r_rd[AW-1:0]];
    end

    logic hv;
    pitr_pkg::t_hit hit;
    pitr_hit #(.COORD_BITS(CB)) u_hit (
        .i_clk, .i_rst_n, .i_valid(r_rvalid),
        .i_px(r_p[0]), .i_py(r_p[1]), .i_pz(r_p[2]),
        .i_va(r_ra), .i_vb(r_rb), .i_vc(r_rc),
        .o_valid(hv), .o_hit(hit)
    );

    logic [2:0] r_drain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_empty  <= 1'b1;
            r_rvalid <= 1'b0;
            r_drain  <= '0;
            for (int i = 0; i < 3; i++) begin
                r_min[i] <= '0;
                r_max[i] <= '0;
            end
        end else begin
            r_rvalid <= 1'b0;
            if (hv && hit.hit) r_hits <= r_hits + 1'b1;
            case (r_state)
                ST_IDLE: if (acc) begin
                    r_inside <= 1'b0;
                    r_cross  <= '0;
                    r_status <= 1'b0;
                    r_state  <= ST_OUT;
                    case (s_in.func)
                        pitr_pkg::FUNC_CLEAR: begin
                            r_count <= '0;
                            r_empty <= 1'b1;
                            for (int i = 0; i < 3; i++) begin
                                r_min[i] <= '0;
                                r_max[i] <= '0;
                            end
                        end
                        pitr_pkg::FUNC_ADD: begin
                            if (full) r_status <= 1'b1;
                            else begin
                                r_count <= r_count + 1'b1;
                                r_empty <= 1'b0;
                                for (int i = 0; i < 3; i++) begin
                                    logic signed [CB-1:0] lo, hi;
                                    lo = v[i];
                                    if (v[3+i] < lo) lo = v[3+i];
                                    if (v[6+i] < lo) lo = v[6+i];
                                    hi = v[i];
                                    if (v[3+i] > hi) hi = v[3+i];
                                    if (v[6+i] > hi) hi = v[6+i];
                                    if (r_empty || lo < r_min[i]) r_min[i] <= lo;
                                    if (r_empty || hi > r_max[i]) r_max[i] <= hi;
                                end
                            end
                        end
                        pitr_pkg::FUNC_QUERY: begin
                            if (in_box) begin
                                for (int i = 0; i < 3; i++) r_p[i] <= v[i];
                                r_rd    <= '0;
                                r_hits  <= '0;
                                r_state <= ST_WALK;
                            end
                        end
                        default: ;
                    endcase
                end
                ST_WALK: begin
                    // issue one read per cycle
                    if (r_rd < r_count) begin
                        r_rvalid <= 1'b1;
                        r_rd     <= r_rd + 1'b1;
                    end else begin
                        r_drain <= '0;
                        r_state <= ST_LAST;
                    end
                end
                ST_LAST: begin
                    // drain read register and unit pipeline
                    r_drain <= r_drain + 1'b1;
                    if (r_drain == 3'd6) begin
                        r_cross  <= pitr_pkg::CROSS_BITS'(r_hits);
                        r_inside <= r_hits[0];
                        r_state  <= ST_OUT;
                    end
                end
                ST_OUT: if (m_out.ready) r_state <= ST_IDLE;
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_out.valid      = (r_state == ST_OUT);
    assign m_out.inside_res = r_inside;
    assign m_out.crossings  = r_cross;
    assign m_out.status     = r_status;
endmodule

// ===== design/pitr_hit.sv =====
// ----------------------------------------------------------------------------
// pitr_hit: pipelined +z ray versus triangle test
// One triangle enters per cycle; its hit flag comes out of the last stage.
// ----------------------------------------------------------------------------
module pitr_hit #(
    parameter int COORD_BITS = pitr_pkg::COORD_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic signed [COORD_BITS-1:0]   i_px, i_py, i_pz,
    input  logic signed [3*COORD_BITS-1:0] i_va, i_vb, i_vc,
    output logic                           o_valid,
    output pitr_pkg::t_hit                 o_hit
);
    localparam int CB = COORD_BITS;
    localparam int DB = CB + 1;        // differences
    localparam int PB = 2 * DB + 1;    // products and their sums
    localparam int TB = PB + DB + 2;   // e2 . q
    localparam int SL = DB + 1;        // low slice of q, unsigned
    localparam int HB = 2 * DB;        // e2 times high slice of q
    localparam int LB = 2 * DB + 2;    // e2 times low slice of q

    // stage 1: box check and differences
    logic signed [CB-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
    assign {az, ay, ax} = i_va;
    assign {bz, by, bx} = i_vb;
    assign {cz, cy, cx} = i_vc;

    logic in_xy;
    always_comb begin
        logic lx, gx, ly, gy;
        lx = (ax < i_px) || (bx < i_px) || (cx < i_px);
        gx = (ax > i_px) || (bx > i_px) || (cx > i_px);
        ly = (ay < i_py) || (by < i_py) || (cy < i_py);
        gy = (ay > i_py) || (by > i_py) || (cy > i_py);
        in_xy = lx && gx && ly && gy;
    end

    logic [3:0] r_v;
    logic       r_box1, r_box2, r_box3;
    logic signed [DB-1:0] r_e1x, r_e1y, r_e1z, r_e2x, r_e2y, r_e2z, r_sx, r_sy, r_sz;
    logic signed [PB-1:0] r_det, r_unum, r_q0, r_q1, r_q2;
    logic signed [DB-1:0] r2_e2x, r2_e2y, r2_e2z;
    logic signed [HB-1:0] r_th0, r_th1, r_th2;
    logic signed [LB-1:0] r_tl0, r_tl1, r_tl2;
    logic signed [PB-1:0] r3_det, r3_unum, r3_vnum;
    logic signed [TB-1:0] t_sum;
    logic                 r_hit;

    function automatic logic hit_rule(input logic signed [PB-1:0] det,
                                      input logic signed [PB-1:0] u,
                                      input logic signed [PB-1:0] v,
                                      input logic signed [TB-1:0] t);
        logic signed [PB:0] uv;
        logic signed [PB:0] d;
        logic ok;
        uv = (PB+1)'(u) + (PB+1)'(v);
        d  = (PB+1)'(det);
        ok = 1'b0;
        if (det > 0)
            ok = (u >= 0) && (u <= det) && (v >= 0) && (uv <= d) && (t > 0);
        else if (det < 0)
            ok = (u <= 0) && (u >= det) && (v <= 0) && (uv >= d) && (t < 0);
        return ok;
    endfunction

    // recombine the split products of e2 with q
    assign t_sum = ((TB'(r_th0) + TB'(r_th1) + TB'(r_th2)) <<< SL)
                 + TB'(r_tl0) + TB'(r_tl1) + TB'(r_tl2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_box1 <= in_xy;
        r_e1x  <= DB'(bx) - DB'(ax);
        r_e1y  <= DB'(by) - DB'(ay);
        r_e1z  <= DB'(bz) - DB'(az);
        r_e2x  <= DB'(cx) - DB'(ax);
        r_e2y  <= DB'(cy) - DB'(ay);
        r_e2z  <= DB'(cz) - DB'(az);
        r_sx   <= DB'(i_px) - DB'(ax);
        r_sy   <= DB'(i_py) - DB'(ay);
        r_sz   <= DB'(i_pz) - DB'(az);
        // stage 2: cross products
        r_box2 <= r_box1;
        r_det  <= PB'(r_e1y * r_e2x) - PB'(r_e1x * r_e2y);
        r_unum <= PB'(r_sy * r_e2x) - PB'(r_sx * r_e2y);
        r_q0   <= PB'(r_sy * r_e1z) - PB'(r_sz * r_e1y);
        r_q1   <= PB'(r_sz * r_e1x) - PB'(r_sx * r_e1z);
        r_q2   <= PB'(r_sx * r_e1y) - PB'(r_sy * r_e1x);
        r2_e2x <= r_e2x;
        r2_e2y <= r_e2y;
        r2_e2z <= r_e2z;
        // stage 3: products of e2 with the high and low slices of q
        r_box3  <= r_box2;
        r_th0   <= HB'(r2_e2x * $signed(r_q0[PB-1:SL]));
        r_th1   <= HB'(r2_e2y * $signed(r_q1[PB-1:SL]));
        r_th2   <= HB'(r2_e2z * $signed(r_q2[PB-1:SL]));
        r_tl0   <= LB'(r2_e2x * $signed({1'b0, r_q0[SL-1:0]}));
        r_tl1   <= LB'(r2_e2y * $signed({1'b0, r_q1[SL-1:0]}));
        r_tl2   <= LB'(r2_e2z * $signed({1'b0, r_q2[SL-1:0]}));
        r3_det  <= r_det;
        r3_unum <= r_unum;
        r3_vnum <= r_q2;
        // stage 4: sum and decide
        r_hit   <= r_box3 && hit_rule(r3_det, r3_unum, r3_vnum, t_sum);
    end

    assign o_valid   = r_v[3];
    assign o_hit.hit = r_hit;
endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the triangle-mesh ray parity block
// Builds small closed meshes and random triangles, then queries points.
// A behavioral copy of the store and the crossing test predicts every result.
// Sender gaps and receiver stalls are varied across several phases.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int HALF_PERIOD = 6;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int NUM_RANDOM  = 328;    // loop passes; tetrahedra add four items each
    localparam int STORE_DEPTH = pitr_pkg::MAX_TRIANGLES_DEF;
    localparam int MAX_COORD   = 524287;
    localparam int MIN_COORD   = -524288;

    typedef logic signed [pitr_pkg::FIELD_BITS-1:0] t_coord;

    typedef struct {
        pitr_pkg::t_func func;
        t_coord v [9];
    } t_cmd;

    typedef struct {
        logic                            inside_res;
        logic [pitr_pkg::CROSS_BITS-1:0] crossings;
        logic                            status;
    } t_res;

    // A directed row: the command plus an optional typed-in result.
    typedef struct {
        t_cmd cmd;
        bit   fixed;
        t_res res;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    pitr_in_if  in_ch ();
    pitr_out_if out_ch ();

    point_in_trimesh_ray_parity_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_in    (in_ch.sink),
        .m_out   (out_ch.source)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Mirror of the block's state.
    longint mesh_a [STORE_DEPTH][3];
    longint mesh_b [STORE_DEPTH][3];
    longint mesh_c [STORE_DEPTH][3];
    int     mesh_count = 0;
    longint box_lo [3];
    longint box_hi [3];
    bit     box_none = 1'b1;

    t_res   expected_q[$];
    int     error_count = 0;
    int     result_count = 0;
    int     query_count = 0;
    int     hit_queries = 0;
    int     idle_pct = 0;
    int     stall_pct = 0;
    longint cycle_count = 0;

    // Exact sign of a.b with 128-bit accumulation.
    function automatic int dot_sign(longint a [3], longint b [3]);
        logic signed [127:0] acc;
        acc = 0;
        for (int i = 0; i < 3; i++)
            acc += 128'(signed'(a[i])) * 128'(signed'(b[i]));
        return (acc > 0) ? 1 : ((acc < 0) ? -1 : 0);
    endfunction

    function automatic longint min_of3(longint a, longint b, longint c);
        longint m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic longint max_of3(longint a, longint b, longint c);
        longint m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    function automatic bit ray_crosses(int k, longint p [3]);
        longint e1 [3];
        longint e2 [3];
        longint s [3];
        longint q [3];
        longint det, unum, vnum;
        int ts;
        if (!(min_of3(mesh_a[k][0], mesh_b[k][0], mesh_c[k][0]) < p[0] &&
              max_of3(mesh_a[k][0], mesh_b[k][0], mesh_c[k][0]) > p[0] &&
              min_of3(mesh_a[k][1], mesh_b[k][1], mesh_c[k][1]) < p[1] &&
              max_of3(mesh_a[k][1], mesh_b[k][1], mesh_c[k][1]) > p[1]))
            return 1'b0;
        for (int i = 0; i < 3; i++) begin
            e1[i] = mesh_b[k][i] - mesh_a[k][i];
            e2[i] = mesh_c[k][i] - mesh_a[k][i];
            s[i]  = p[i] - mesh_a[k][i];
        end
        det = e1[1] * e2[0] - e1[0] * e2[1];
        if (det == 0)
            return 1'b0;
        unum = s[1] * e2[0] - s[0] * e2[1];
        q[0] = s[1] * e1[2] - s[2] * e1[1];
        q[1] = s[2] * e1[0] - s[0] * e1[2];
        q[2] = s[0] * e1[1] - s[1] * e1[0];
        vnum = q[2];
        ts = dot_sign(e2, q);
        if (det > 0) begin
            if (unum < 0 || unum > det) return 1'b0;
            if (vnum < 0 || unum + vnum > det) return 1'b0;
            return ts > 0;
        end
        if (unum > 0 || unum < det) return 1'b0;
        if (vnum > 0 || unum + vnum < det) return 1'b0;
        return ts < 0;
    endfunction

    // Advance the mirrored state by one command and return its result.
    function automatic t_res mesh_apply(t_cmd c);
        t_res r;
        longint p [3];
        longint lo, hi;
        int n;
        bit in_box;
        r = '{1'b0, '0, 1'b0};
        case (c.func)
            pitr_pkg::FUNC_CLEAR: begin
                mesh_count = 0;
                box_none = 1'b1;
                box_lo = '{0, 0, 0};
                box_hi = '{0, 0, 0};
            end
            pitr_pkg::FUNC_ADD: begin
                if (mesh_count >= STORE_DEPTH) begin
                    r.status = 1'b1;
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        mesh_a[mesh_count][i] = c.v[i];
                        mesh_b[mesh_count][i] = c.v[3+i];
                        mesh_c[mesh_count][i] = c.v[6+i];
                        lo = c.v[i];
                        hi = c.v[i];
                        if (c.v[3+i] < lo) lo = c.v[3+i];
                        if (c.v[6+i] < lo) lo = c.v[6+i];
                        if (c.v[3+i] > hi) hi = c.v[3+i];
                        if (c.v[6+i] > hi) hi = c.v[6+i];
                        if (box_none || lo < box_lo[i]) box_lo[i] = lo;
                        if (box_none || hi > box_hi[i]) box_hi[i] = hi;
                    end
                    box_none = 1'b0;
                    mesh_count++;
                end
            end
            pitr_pkg::FUNC_QUERY: begin
                in_box = !box_none;
                for (int i = 0; i < 3; i++) begin
                    p[i] = c.v[i];
                    if (p[i] < box_lo[i] || p[i] > box_hi[i]) in_box = 1'b0;
                end
                if (in_box) begin
                    n = 0;
                    for (int k = 0; k < mesh_count; k++)
                        if (ray_crosses(k, p)) n++;
                    r.crossings  = n[pitr_pkg::CROSS_BITS-1:0];
                    r.inside_res = n[0];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic t_cmd make_cmd(pitr_pkg::t_func f, int c0, int c1, int c2, int c3,
                                      int c4, int c5, int c6, int c7, int c8);
        t_cmd c;
        c.func = f;
        c.v = '{t_coord'(c0), t_coord'(c1), t_coord'(c2), t_coord'(c3), t_coord'(c4),
                t_coord'(c5), t_coord'(c6), t_coord'(c7), t_coord'(c8)};
        return c;
    endfunction

    function automatic t_cmd rand_cmd(pitr_pkg::t_func f);
        t_cmd c;
        c.func = f;
        for (int i = 0; i < 9; i++) c.v[i] = t_coord'($urandom);
        return c;
    endfunction

    // Coordinate near an origin, kept inside the field range.
    function automatic int near(int base, int spread);
        longint v;
        v = longint'(base) + $urandom_range(2 * spread) - spread;
        if (v > MAX_COORD) v = MAX_COORD;
        if (v < MIN_COORD) v = MIN_COORD;
        return int'(v);
    endfunction

    // Drive one item at a falling edge and hold it until accepted.
    task automatic send_item(t_cmd c);
        t_res r;
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) @(negedge i_clk);
        in_ch.valid    <= 1'b1;
        in_ch.func     <= c.func;
        in_ch.vert_a_x <= c.v[0];
        in_ch.vert_a_y <= c.v[1];
        in_ch.vert_a_z <= c.v[2];
        in_ch.vert_b_x <= c.v[3];
        in_ch.vert_b_y <= c.v[4];
        in_ch.vert_b_z <= c.v[5];
        in_ch.vert_c_x <= c.v[6];
        in_ch.vert_c_y <= c.v[7];
        in_ch.vert_c_z <= c.v[8];
        do @(posedge i_clk); while (!in_ch.ready);
        r = mesh_apply(c);
        expected_q.push_back(r);
        if (c.func == pitr_pkg::FUNC_QUERY) begin
            query_count++;
            if (r.crossings != 0) hit_queries++;
        end
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
    endtask

    // Directed row with a typed-in result: compare the predictor to it too.
    task automatic send_row(t_row row);
        t_res r;
        t_cmd c;
        c = row.cmd;
        send_item(c);
        r = expected_q[$];
        if (row.fixed && (r.inside_res !== row.res.inside_res ||
                          r.crossings !== row.res.crossings ||
                          r.status !== row.res.status)) begin
            $error("directed row: predictor gave %0d/%0d/%0d", r.inside_res,
                   r.crossings, r.status);
            error_count++;
        end
    endtask

    task automatic drain();
        while (expected_q.size() != 0) @(negedge i_clk);
    endtask

    // Closed tetrahedron around (cx,cy,cz) with half size h.
    task automatic add_tetra(int cx, int cy, int cz, int h);
        send_item(make_cmd(pitr_pkg::FUNC_ADD, cx-h, cy-h, cz-h, cx+h, cy-h, cz-h,
                           cx, cy+h, cz-h));
        send_item(make_cmd(pitr_pkg::FUNC_ADD, cx-h, cy-h, cz-h, cx+h, cy-h, cz-h,
                           cx, cy, cz+h));
        send_item(make_cmd(pitr_pkg::FUNC_ADD, cx+h, cy-h, cz-h, cx, cy+h, cz-h,
                           cx, cy, cz+h));
        send_item(make_cmd(pitr_pkg::FUNC_ADD, cx, cy+h, cz-h, cx-h, cy-h, cz-h,
                           cx, cy, cz+h));
    endtask

    // Receiver side: stall at random, check each result against the oldest prediction.
    always @(negedge i_clk) begin
        if (!i_rst_n) out_ch.ready <= 1'b0;
        else out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        t_res e;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            result_count <= result_count + 1;
            if (expected_q.size() == 0) begin
                $error("result item with nothing expected");
                error_count++;
            end else begin
                e = expected_q.pop_front();
                if (out_ch.inside_res !== e.inside_res) begin
                    $error("inside_res expected %0d actual %0d", e.inside_res,
                           out_ch.inside_res);
                    error_count++;
                end
                if (out_ch.crossings !== e.crossings) begin
                    $error("crossings expected %0d actual %0d", e.crossings,
                           out_ch.crossings);
                    error_count++;
                end
                if (out_ch.status !== e.status) begin
                    $error("status expected %0d actual %0d", e.status, out_ch.status);
                    error_count++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        t_row rows [$];
        t_res zero_res;
        int f, cx, cy, h;
        zero_res = '{1'b0, '0, 1'b0};
        in_ch.valid = 1'b0;
        in_ch.func = pitr_pkg::FUNC_CLEAR;
        {in_ch.vert_a_x, in_ch.vert_a_y, in_ch.vert_a_z} = '0;
        {in_ch.vert_b_x, in_ch.vert_b_y, in_ch.vert_b_z} = '0;
        {in_ch.vert_c_x, in_ch.vert_c_y, in_ch.vert_c_z} = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table: empty store, extremes, unused code, single triangles,
        // degenerate and boundary cases.
        rows.push_back('{make_cmd(pitr_pkg::FUNC_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                         1, zero_res});
        rows.push_back('{make_cmd(pitr_pkg::FUNC_NONE, -1, -1, -1, -1, -1, -1, -1, -1, -1),
                         1, zero_res});
        rows.push_back('{make_cmd(pitr_pkg::FUNC_ADD, MIN_COORD, MIN_COORD, MIN_COORD,
                         MAX_COORD, MIN_COORD, MAX_COORD, 0, MAX_COORD, 0), 1, zero_res});
        rows.push_back('{make_cmd(pitr_pkg::FUNC_QUERY, 0, 0, MIN_COORD, 0, 0, 0, 0, 0, 0),
                         0, zero_res});
        rows.push_back('{make_cmd(pitr_pkg::FUNC_QUERY, MAX_COORD, MAX_COORD, MAX_COORD,
                         0, 0, 0, 0, 0, 0), 0, zero_res});
        rows.push_back('{make_cmd(pitr_pkg::FUNC_CLEAR, MAX_COORD, MAX_COORD, MAX_COORD,
                         MAX_COORD, MAX_COORD, MAX_COORD, MAX_COORD, MAX_COORD, MAX_COORD),
                         1, zero_res});
        rows.push_back('{make_cmd(pitr_pkg::FUNC_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                         1, zero_res});
        // degenerate (collinear in x/y) triangle: never counted
        rows.push_back('{make_cmd(pitr_pkg::FUNC_ADD, 0, 0, -100, 100, 100, 0, 200, 200,
                         100), 1, zero_res});
        rows.push_back('{make_cmd(pitr_pkg::FUNC_QUERY, 100, 100, -100, 0, 0, 0, 0, 0, 0),
                         0, zero_res});
        rows.push_back('{make_cmd(pitr_pkg::FUNC_ADD, -256, -256, 256, 256, -256, 256, 0,
                         256, 256), 1, zero_res});
        rows.push_back('{make_cmd(pitr_pkg::FUNC_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                         0, zero_res});
        // point outside the box on z only
        rows.push_back('{make_cmd(pitr_pkg::FUNC_QUERY, 0, 0, 300, 0, 0, 0, 0, 0, 0),
                         1, zero_res});
        rows.push_back('{make_cmd(pitr_pkg::FUNC_QUERY, 0, 0, -101, 0, 0, 0, 0, 0, 0),
                         1, zero_res});
        // on a vertex of the x/y box: excluded by the strict test
        rows.push_back('{make_cmd(pitr_pkg::FUNC_QUERY, -256, -256, 0, 0, 0, 0, 0, 0, 0),
                         0, zero_res});
        rows.push_back('{make_cmd(pitr_pkg::FUNC_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                         1, zero_res});
        foreach (rows[i]) send_row(rows[i]);

        add_tetra(0, 0, 0, 4096);
        send_item(make_cmd(pitr_pkg::FUNC_QUERY, 10, 20, -30, 0, 0, 0, 0, 0, 0));
        send_item(make_cmd(pitr_pkg::FUNC_QUERY, 3000, 3000, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_cmd(pitr_pkg::FUNC_QUERY, 0, 4096, -4096, 0, 0, 0, 0, 0, 0));
        // Hold the sender until every result is back.
        drain();
        send_item(make_cmd(pitr_pkg::FUNC_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0));

        // Random part: mostly small meshes of tetrahedra with nearby queries,
        // plus noise triangles, full-range items and unused codes.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 50; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 50; end
                default: begin idle_pct = 35; stall_pct = 35; end
            endcase
            for (int n = 0; n < NUM_RANDOM / 4; n++) begin
                f = $urandom_range(99);
                cx = $signed($urandom_range(800000)) - 400000;
                cy = $signed($urandom_range(800000)) - 400000;
                h = 64 << $urandom_range(8);
                if (f < 4) begin
                    send_item(make_cmd(pitr_pkg::FUNC_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0));
                end else if (f < 14 && mesh_count < 200) begin
                    add_tetra(cx, cy, near(0, 100000), h);
                end else if (f < 24 && mesh_count < 200) begin
                    send_item(make_cmd(pitr_pkg::FUNC_ADD, near(cx, h), near(cy, h),
                                       near(0, h), near(cx, h), near(cy, h), near(0, h),
                                       near(cx, h), near(cy, h), near(0, h)));
                end else if (f < 28 && mesh_count < 200) begin
                    send_item(rand_cmd(pitr_pkg::FUNC_ADD));
                end else if (f < 31) begin
                    send_item(rand_cmd(pitr_pkg::FUNC_NONE));
                end else if (f < 36) begin
                    send_item(rand_cmd(pitr_pkg::FUNC_QUERY));
                end else if (mesh_count > 0) begin
                    h = $urandom_range(mesh_count - 1);
                    send_item(make_cmd(pitr_pkg::FUNC_QUERY,
                        near(int'((mesh_a[h][0] + mesh_b[h][0] + mesh_c[h][0]) / 3), 2000),
                        near(int'((mesh_a[h][1] + mesh_b[h][1] + mesh_c[h][1]) / 3), 2000),
                        near(int'(mesh_a[h][2]), 8000), 0, 0, 0, 0, 0, 0));
                end else begin
                    send_item(rand_cmd(pitr_pkg::FUNC_QUERY));
                end
            end
            drain();
        end

        repeat (50) @(posedge i_clk);
        $display("Covered %0d queries (%0d with crossings) and %0d results in total.",
                 query_count, hit_queries, result_count);
        if (error_count == 0 && expected_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
